### hdl/ttag_pkg.sv
`default_nettype none

package ttag_pkg;

  // Default build sizes.
  localparam int DEF_MAX_DIMS   = 6;
  localparam int DEF_SIZE_BITS  = 16;
  localparam int DEF_INDEX_BITS = 32;

  // Fixed register file layout.
  localparam int SIZE_REGS    = 6;
  localparam int RANK_W       = 3;
  localparam int AXIS_W       = 3;
  localparam int AXIS_ORDER_W = 18;
  localparam int SIZE_REG_W   = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 18;
  localparam int OUT_BITS     = 32;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RANK       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_ORDER = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SIZE0      = 3'd2;

  // Register reset values: rank one, identity axis order, unit sizes.
  localparam logic [RANK_W-1:0]       RANK_RESET       = 3'd1;
  localparam logic [AXIS_ORDER_W-1:0] AXIS_ORDER_RESET = 18'd181896;
  localparam logic [SIZE_REG_W-1:0]   SIZE_RESET       = 16'd1;

  // Status handed from the setup sequencer to the walker.
  typedef struct packed {
    logic busy;
    logic order_bad;
  } setup_status_t;

endpackage

`default_nettype wire

### hdl/tensor_transpose_address_gen_core.sv
`default_nettype none

// Transpose address generator. Program rank, axis order and the input sizes
// through the write port; each accepted word then yields one (src_index,
// dst_index) pair of the transposed tensor in output row-major order, with
// last_element on the final pair and order_error when the axis order is not
// a permutation of the rank. After reset and after every register write an
// internal setup pass runs with in_ready low; a shift-add multiplier forms
// the stride products one bit per cycle, a size of zero counting as one.
// Once setup is done one word is accepted every cycle while no register is
// written and the output register is free or being taken, and its pair is
// ready in the output register in the next cycle; a word can be taken while
// the previous pair is being taken. Any register write returns the walk to
// element zero.
module tensor_transpose_address_gen_core #(
  parameter int MAX_DIMS   = ttag_pkg::DEF_MAX_DIMS,
  parameter int SIZE_BITS  = ttag_pkg::DEF_SIZE_BITS,
  parameter int INDEX_BITS = ttag_pkg::DEF_INDEX_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ttag_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ttag_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               restart,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ttag_pkg::OUT_BITS-1:0]      src_index,
  output logic [ttag_pkg::OUT_BITS-1:0]      dst_index,
  output logic                               last_element,
  output logic                               order_error
);
  import ttag_pkg::*;

  localparam int NDIM  = (MAX_DIMS < SIZE_REGS) ? MAX_DIMS : SIZE_REGS;
  localparam int CMP_W = CFG_INDEX_W + 1;

  logic [RANK_W-1:0]       rank_reg;
  logic [AXIS_ORDER_W-1:0] axis_order_reg;
  logic [SIZE_REG_W-1:0]   size_reg [NDIM];

  setup_status_t           status;
  logic [INDEX_BITS-1:0]   jump [NDIM];
  logic [SIZE_BITS-1:0]    osize_max [NDIM];
  logic [NDIM-1:0]         active;
  logic                    take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rank_reg       <= RANK_RESET;
      axis_order_reg <= AXIS_ORDER_RESET;
      for (int d = 0; d < NDIM; d++) begin
        size_reg[d] <= SIZE_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_RANK) begin
        rank_reg <= cfg_data[RANK_W-1:0];
      end else if (cfg_index == REG_AXIS_ORDER) begin
        axis_order_reg <= cfg_data[AXIS_ORDER_W-1:0];
      end else begin
        for (int d = 0; d < NDIM; d++) begin
          if (CMP_W'(cfg_index) == CMP_W'(REG_SIZE0) + CMP_W'(d)) begin
            size_reg[d] <= cfg_data[SIZE_REG_W-1:0];
          end
        end
      end
    end
  end

  // Words flow whenever setup is done, no register is being written and the output register can take one.
  assign in_ready = !status.busy && !cfg_we && (!out_valid || out_ready);
  assign take     = in_valid && in_ready;

  ttag_setup #(
    .NDIM       (NDIM),
    .SIZE_BITS  (SIZE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_setup (
    .clk            (clk),
    .rst            (rst),
    .start          (cfg_we),
    .rank_reg       (rank_reg),
    .axis_order_reg (axis_order_reg),
    .size_reg       (size_reg),
    .status         (status),
    .jump           (jump),
    .osize_max      (osize_max),
    .active         (active)
  );

  ttag_walk #(
    .NDIM       (NDIM),
    .SIZE_BITS  (SIZE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .restart      (restart),
    .clear        (cfg_we),
    .status       (status),
    .jump         (jump),
    .osize_max    (osize_max),
    .active       (active),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .src_index    (src_index),
    .dst_index    (dst_index),
    .last_element (last_element),
    .order_error  (order_error)
  );

endmodule

`default_nettype wire

### hdl/ttag_setup.sv
`default_nettype none

module ttag_setup #(
  parameter int NDIM       = 6,
  parameter int SIZE_BITS  = 16,
  parameter int INDEX_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [ttag_pkg::RANK_W-1:0]           rank_reg,
  input  logic [ttag_pkg::AXIS_ORDER_W-1:0]     axis_order_reg,
  input  logic [ttag_pkg::SIZE_REG_W-1:0]       size_reg [NDIM],
  output ttag_pkg::setup_status_t               status,
  output logic [INDEX_BITS-1:0]                 jump [NDIM],
  output logic [SIZE_BITS-1:0]                  osize_max [NDIM],
  output logic [NDIM-1:0]                       active
);
  import ttag_pkg::*;

  localparam int DIM_BITS = (NDIM > 1) ? $clog2(NDIM) : 1;
  localparam int P_BITS   = $clog2(NDIM + 1);
  localparam int P_DEPTH  = 2 ** P_BITS;
  localparam int CMP_W    = AXIS_W + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_LOAD  = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_JREAD = 3'd4;
  localparam logic [2:0] ST_JCALC = 3'd5;

  logic [2:0]            state;
  logic [DIM_BITS-1:0]   cnt;
  logic [INDEX_BITS-1:0] prod [P_DEPTH];
  logic [INDEX_BITS-1:0] mcand;
  logic [SIZE_BITS-1:0]  mplier;
  logic [INDEX_BITS-1:0] mul_acc;
  logic [INDEX_BITS-1:0] qreg;
  logic [INDEX_BITS-1:0] off_sum;
  logic                  order_bad;

  logic [AXIS_W-1:0]     cur_ax;
  logic [DIM_BITS-1:0]   sz_idx;
  logic [SIZE_REG_W-1:0] size_rd;
  logic [SIZE_BITS-1:0]  s_trunc;
  logic [SIZE_BITS-1:0]  s_eff;
  logic [CMP_W-1:0]      p_addr_w;
  logic [INDEX_BITS-1:0] p_rd;
  logic                  cnt_in;
  logic                  bad_comb;
  logic [INDEX_BITS-1:0] mul_acc_next;
  logic [SIZE_BITS-1:0]  mplier_sh;

  // Source axis of the output dimension under the counter.
  assign cur_ax = axis_order_reg[AXIS_W*cnt +: AXIS_W];
  assign cnt_in = CMP_W'(cnt) < CMP_W'(rank_reg);

  // One size read port: input axis in the product phase, source axis otherwise.
  assign sz_idx  = (state == ST_LOAD) ? cnt : cur_ax[DIM_BITS-1:0];
  assign size_rd = (CMP_W'(sz_idx) < CMP_W'(NDIM)) ? size_reg[sz_idx] : SIZE_RESET;
  assign s_trunc = SIZE_BITS'(size_rd);
  assign s_eff   = (s_trunc == '0) ? SIZE_BITS'(1) : s_trunc;

  // One read port into the suffix products.
  always_comb begin
    case (state)
      ST_LOAD:  p_addr_w = CMP_W'(cnt) + CMP_W'(1);
      ST_JREAD: p_addr_w = CMP_W'(cur_ax) + CMP_W'(1);
      default:  p_addr_w = CMP_W'(cur_ax);
    endcase
  end
  assign p_rd = prod[p_addr_w[P_BITS-1:0]];

  // Shift-add multiplier step.
  assign mul_acc_next = mul_acc + (mplier[0] ? mcand : '0);
  assign mplier_sh    = mplier >> 1;

  // The axis order must name every axis below the rank exactly once.
  always_comb begin : order_check
    logic [7:0]        seen;
    logic [AXIS_W-1:0] a;
    seen     = '0;
    a        = '0;
    bad_comb = (rank_reg == '0) || (CMP_W'(rank_reg) > CMP_W'(NDIM));
    for (int d = 0; d < NDIM; d++) begin
      if (CMP_W'(d) < CMP_W'(rank_reg)) begin
        a = axis_order_reg[AXIS_W*d +: AXIS_W];
        if ((a >= rank_reg) || seen[a]) begin
          bad_comb = 1'b1;
        end
        seen[a] = 1'b1;
      end
    end
  end

  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      active[d] = CMP_W'(d) < CMP_W'(rank_reg);
    end
  end

  assign status.busy      = (state != ST_IDLE);
  assign status.order_bad = order_bad;

  // Setup sequencer: suffix products of the input sizes, then the per-dimension
  // source jumps taken when the odometer carries into that dimension.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_START;
      cnt       <= '0;
      order_bad <= 1'b0;
    end else begin
      if (state != ST_IDLE) begin
        order_bad <= bad_comb;
      end
      if (start) begin
        state <= ST_START;
      end else begin
        case (state)
          ST_IDLE: begin
            state <= ST_IDLE;
          end
          ST_START: begin
            prod[P_BITS'(NDIM)] <= INDEX_BITS'(1);
            cnt                 <= DIM_BITS'(NDIM - 1);
            state               <= ST_LOAD;
          end
          ST_LOAD: begin
            if (cnt_in) begin
              mcand   <= p_rd;
              mplier  <= s_eff;
              mul_acc <= '0;
              state   <= ST_MUL;
            end else begin
              prod[P_BITS'(cnt)] <= INDEX_BITS'(1);
              if (cnt == '0) begin
                cnt     <= DIM_BITS'(NDIM - 1);
                off_sum <= '0;
                state   <= ST_JREAD;
              end else begin
                cnt <= cnt - DIM_BITS'(1);
              end
            end
          end
          ST_MUL: begin
            mul_acc <= mul_acc_next;
            mcand   <= mcand << 1;
            mplier  <= mplier_sh;
            if (mplier_sh == '0) begin
              prod[P_BITS'(cnt)] <= mul_acc_next;
              if (cnt == '0) begin
                cnt     <= DIM_BITS'(NDIM - 1);
                off_sum <= '0;
                state   <= ST_JREAD;
              end else begin
                cnt   <= cnt - DIM_BITS'(1);
                state <= ST_LOAD;
              end
            end
          end
          ST_JREAD: begin
            if (cnt_in) begin
              qreg           <= p_rd;
              osize_max[cnt] <= s_eff - SIZE_BITS'(1);
              state          <= ST_JCALC;
            end else begin
              osize_max[cnt] <= '0;
              jump[cnt]      <= '0;
              if (cnt == '0) begin
                state <= ST_IDLE;
              end else begin
                cnt <= cnt - DIM_BITS'(1);
              end
            end
          end
          ST_JCALC: begin
            // Step along this axis, rewinding every inner output dimension.
            jump[cnt] <= qreg - off_sum;
            off_sum   <= off_sum + (p_rd - qreg);
            if (cnt == '0) begin
              state <= ST_IDLE;
            end else begin
              cnt   <= cnt - DIM_BITS'(1);
              state <= ST_JREAD;
            end
          end
          default: begin
            state <= ST_START;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ttag_walk.sv
`default_nettype none

module ttag_walk #(
  parameter int NDIM       = 6,
  parameter int SIZE_BITS  = 16,
  parameter int INDEX_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  logic                              restart,
  input  logic                              clear,
  input  ttag_pkg::setup_status_t           status,
  input  logic [INDEX_BITS-1:0]             jump [NDIM],
  input  logic [SIZE_BITS-1:0]              osize_max [NDIM],
  input  logic [NDIM-1:0]                   active,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [ttag_pkg::OUT_BITS-1:0]     src_index,
  output logic [ttag_pkg::OUT_BITS-1:0]     dst_index,
  output logic                              last_element,
  output logic                              order_error
);
  import ttag_pkg::*;

  localparam int DIM_BITS = (NDIM > 1) ? $clog2(NDIM) : 1;

  logic [SIZE_BITS-1:0]  pos [NDIM];
  logic [INDEX_BITS-1:0] cur_src;
  logic [INDEX_BITS-1:0] cur_dst;

  logic [SIZE_BITS-1:0]  base_pos [NDIM];
  logic [SIZE_BITS-1:0]  pos_next [NDIM];
  logic [INDEX_BITS-1:0] base_src;
  logic [INDEX_BITS-1:0] base_dst;
  logic [INDEX_BITS-1:0] src_next;
  logic [INDEX_BITS-1:0] dst_next;
  logic [NDIM-1:0]       at_max;
  logic [DIM_BITS-1:0]   sel;
  logic                  found;
  logic                  is_last;

  // A restart clears the position before this word is produced.
  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      base_pos[d] = restart ? '0 : pos[d];
      at_max[d]   = !active[d] || (base_pos[d] == osize_max[d]);
    end
  end
  assign base_src = restart ? '0 : cur_src;
  assign base_dst = restart ? '0 : cur_dst;
  assign is_last  = &at_max;

  // Innermost dimension that can still count up.
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int d = 0; d < NDIM; d++) begin
      if (!at_max[d]) begin
        sel   = DIM_BITS'(d);
        found = 1'b1;
      end
    end
  end

  // Odometer step; past the final element everything returns to zero.
  always_comb begin
    for (int d = 0; d < NDIM; d++) begin
      if (!found || (DIM_BITS'(d) > sel)) begin
        pos_next[d] = '0;
      end else if (DIM_BITS'(d) == sel) begin
        pos_next[d] = base_pos[d] + SIZE_BITS'(1);
      end else begin
        pos_next[d] = base_pos[d];
      end
    end
    src_next = found ? (base_src + jump[sel]) : '0;
    dst_next = found ? (base_dst + INDEX_BITS'(1)) : '0;
  end

  // Position state.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int d = 0; d < NDIM; d++) begin
        pos[d] <= '0;
      end
      cur_src <= '0;
      cur_dst <= '0;
    end else if (take) begin
      if (status.order_bad) begin
        for (int d = 0; d < NDIM; d++) begin
          pos[d] <= '0;
        end
        cur_src <= '0;
        cur_dst <= '0;
      end else begin
        pos     <= pos_next;
        cur_src <= src_next;
        cur_dst <= dst_next;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (status.order_bad) begin
        src_index    <= '0;
        dst_index    <= '0;
        last_element <= 1'b1;
        order_error  <= 1'b1;
      end else begin
        src_index    <= OUT_BITS'(base_src);
        dst_index    <= OUT_BITS'(base_dst);
        last_element <= is_last;
        order_error  <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### hdl/ttag_checker.sv
`default_nettype none

module ttag_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           restart,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [ttag_pkg::OUT_BITS-1:0]  src_index,
  input wire logic [ttag_pkg::OUT_BITS-1:0]  dst_index,
  input wire logic                           last_element,
  input wire logic                           order_error
);

  // A pending word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(src_index) && $stable(dst_index))
    else $error("pending output word changed before it was taken");

  // Every accepted word shows up in the output register in the next cycle.
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no output");

  // A restart always gives output element zero.
  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && restart |=> dst_index == '0)
    else $error("restart did not return to element zero");

  // An error word carries zero indices and marks the end.
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && order_error |-> last_element && src_index == '0 && dst_index == '0)
    else $error("error word has wrong contents");

endmodule

bind tensor_transpose_address_gen_core ttag_checker u_ttag_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .restart      (restart),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .src_index    (src_index),
  .dst_index    (dst_index),
  .last_element (last_element),
  .order_error  (order_error)
);

`default_nettype wire
